FILE: rtl/rabf_pkg.sv
package rabf_pkg;

  localparam int BLOCK_FRAMES    = 64;
  localparam int MAX_BLOCK_COUNT = 32;
  localparam int SLOT_COUNT      = MAX_BLOCK_COUNT + 1;
  localparam int STORE_DEPTH     = SLOT_COUNT * BLOCK_FRAMES;
  localparam int ADDR_W          = $clog2(STORE_DEPTH);
  localparam int POS_W           = $clog2(BLOCK_FRAMES);
  localparam int SLOT_W          = $clog2(SLOT_COUNT);
  localparam int CNT_W           = $clog2(MAX_BLOCK_COUNT + 1);
  localparam int SAMPLE_W        = 32;
  localparam int PCT_W           = 7;
  localparam int FULL_PCT        = 100;
  localparam int DIVD_W          = $clog2(FULL_PCT * MAX_BLOCK_COUNT + 1);
  localparam int DIV_CNT_W       = $clog2(DIVD_W + 1);
  localparam int RATE_W          = 4;
  localparam int REG_W           = 6;
  localparam int CFG_IDX_W       = 2;
  localparam int MODE_W          = 2;
  localparam int OUT_USER_W      = 3;
  localparam int OUT_DATA_W      = ((SAMPLE_W + PCT_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PREBUF = 2'd2;

  localparam logic [RATE_W-1:0] RATE_RESET   = 4'd6;
  localparam logic [REG_W-1:0]  MAX_RESET    = 6'd32;
  localparam logic [REG_W-1:0]  PREBUF_RESET = 6'd10;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_FLUSH = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PUSH,
    S_DIV_GO,
    S_DIV_WAIT,
    S_ST_WAIT,
    S_FRM_RD,
    S_FRM_LD,
    S_FRM_WAIT
  } state_t;

  typedef struct packed {
    logic latch;
    logic decode;
    logic copy_step;
    logic flush;
    logic pop_decide;
    logic div_start;
    logic load_status;
    logic frame_rd;
    logic load_frame;
    logic frame_next;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  copy_last;
    logic  div_busy;
    logic  out_fire;
    logic  frame_last;
  } stat_t;

  function automatic logic [RATE_W-1:0] rate_mult(input logic [RATE_W-1:0] sel);
    logic [RATE_W-1:0] m;
    unique case (sel)
      4'd0:    m = 4'd11;
      4'd1:    m = 4'd4;
      4'd2:    m = 4'd11;
      4'd3:    m = 4'd2;
      4'd4:    m = 4'd11;
      4'd5:    m = 4'd11;
      4'd8:    m = 4'd11;
      default: m = 4'd1;
    endcase
    return m;
  endfunction

  function automatic logic [RATE_W-1:0] rate_div(input logic [RATE_W-1:0] sel);
    logic [RATE_W-1:0] d;
    unique case (sel)
      4'd0:    d = 4'd2;
      4'd2:    d = 4'd4;
      4'd4:    d = 4'd6;
      4'd5:    d = 4'd8;
      4'd8:    d = 4'd12;
      default: d = 4'd1;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/rabf_ram.sv
module rabf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2112
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/rabf_div.sv
module rabf_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rabf_pkg::DIVD_W-1:0]  dividend,
  input  logic [rabf_pkg::CNT_W-1:0]   divisor,
  output logic                         busy,
  output logic [rabf_pkg::DIVD_W-1:0]  quotient
);
  import rabf_pkg::*;

  logic [DIVD_W-1:0]    work_r, work_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [CNT_W:0]       trial;
  logic                 ge;

  // one quotient bit per cycle, shift and subtract
  always_comb begin
    trial    = {rem_r, work_r[DIVD_W-1]};
    ge       = trial >= {1'b0, divisor};
    work_nxt = work_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      work_nxt = dividend;
      rem_nxt  = '0;
      cnt_nxt  = DIV_CNT_W'(DIVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? CNT_W'(trial - {1'b0, divisor}) : CNT_W'(trial);
      work_nxt = {work_r[DIVD_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = cnt_r != DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
  end

  assign busy     = busy_r;
  assign quotient = work_r;

endmodule

FILE: rtl/rabf_dp.sv
module rabf_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rabf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rabf_pkg::REG_W-1:0]        cfg_data,
  input  logic [rabf_pkg::SAMPLE_W-1:0]     in_tdata,
  input  logic [rabf_pkg::MODE_W-1:0]       in_tuser,
  input  rabf_pkg::cmd_t                    cmd,
  output rabf_pkg::stat_t                   stat,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rabf_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [rabf_pkg::OUT_USER_W-1:0]   out_tuser,
  output logic                              out_tlast
);
  import rabf_pkg::*;

  logic [RATE_W-1:0]   rate_r;
  logic [REG_W-1:0]    max_r;
  logic [REG_W-1:0]    prebuf_r;

  mode_t               mode_r;
  logic [SAMPLE_W-1:0] frame_r;
  logic                rej_r;

  logic [RATE_W-1:0]   phase_r, phase_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0]    cb_r, cb_nxt;
  logic [SLOT_W-1:0]   head_r, head_nxt;
  logic [SLOT_W-1:0]   tail_r, tail_nxt;
  logic                preb_r, preb_nxt;
  logic [RATE_W-1:0]   copy_r, copy_nxt;

  logic [SLOT_W-1:0]   pop_slot_r;
  logic                sil_r;
  logic [POS_W-1:0]    k_r;

  logic                out_valid_r;
  logic                out_status_r;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic                out_sil_r;
  logic                out_last_r;
  logic                out_rej_r;
  logic [PCT_W-1:0]    out_pct_r;

  logic [CNT_W-1:0]    eff_max;
  logic [CNT_W-1:0]    eff_thr;
  logic [RATE_W-1:0]   mult;
  logic [RATE_W-1:0]   dv;
  logic [RATE_W-1:0]   phase_inc;
  logic                keep;
  logic                use_blk;
  logic [SLOT_W-1:0]   tail_inc;
  logic [SLOT_W-1:0]   head_inc;
  logic [ADDR_W-1:0]   waddr;
  logic [ADDR_W-1:0]   raddr;
  logic [SAMPLE_W-1:0] rdata;
  logic                div_busy;
  logic [DIVD_W-1:0]   quotient;
  logic [PCT_W-1:0]    fill_pct;
  logic                out_fire;

  always_comb begin
    if (max_r == '0) begin
      eff_max = CNT_W'(1);
    end else if (max_r > REG_W'(MAX_BLOCK_COUNT)) begin
      eff_max = CNT_W'(MAX_BLOCK_COUNT);
    end else begin
      eff_max = CNT_W'(max_r);
    end
    if (prebuf_r == '0) begin
      eff_thr = CNT_W'(1);
    end else if (prebuf_r > REG_W'(eff_max)) begin
      eff_thr = eff_max;
    end else begin
      eff_thr = CNT_W'(prebuf_r);
    end
  end

  assign mult      = rate_mult(rate_r);
  assign dv        = rate_div(rate_r);
  assign phase_inc = phase_r + 1'b1;
  assign keep      = phase_inc >= dv;
  assign tail_inc  = (tail_r == SLOT_W'(SLOT_COUNT - 1)) ? '0 : tail_r + 1'b1;
  assign head_inc  = (head_r == SLOT_W'(SLOT_COUNT - 1)) ? '0 : head_r + 1'b1;
  assign waddr     = ADDR_W'(tail_r) * ADDR_W'(BLOCK_FRAMES) + ADDR_W'(pos_r);
  assign raddr     = ADDR_W'(pop_slot_r) * ADDR_W'(BLOCK_FRAMES) + ADDR_W'(k_r);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    cb_nxt    = cb_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    preb_nxt  = preb_r;
    copy_nxt  = copy_r;
    use_blk   = 1'b0;
    if (cmd.flush) begin
      phase_nxt = '0;
      pos_nxt   = '0;
      cb_nxt    = '0;
      head_nxt  = '0;
      tail_nxt  = '0;
      preb_nxt  = 1'b1;
    end
    if (cmd.decode) begin
      copy_nxt = '0;
    end
    if (cmd.copy_step) begin
      copy_nxt = copy_r + 1'b1;
      if (keep) begin
        phase_nxt = '0;
        if (pos_r == POS_W'(BLOCK_FRAMES - 1)) begin
          pos_nxt  = '0;
          tail_nxt = tail_inc;
          cb_nxt   = cb_r + 1'b1;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end else begin
        phase_nxt = phase_inc;
      end
    end
    if (cmd.pop_decide) begin
      if (preb_r) begin
        if (cb_r >= eff_thr) begin
          preb_nxt = 1'b0;
          use_blk  = 1'b1;
        end
      end else if (cb_r == '0) begin
        preb_nxt = 1'b1;
      end else begin
        use_blk = 1'b1;
      end
      if (use_blk) begin
        head_nxt = head_inc;
        cb_nxt   = cb_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r      <= RATE_RESET;
      max_r       <= MAX_RESET;
      prebuf_r    <= PREBUF_RESET;
      phase_r     <= '0;
      pos_r       <= '0;
      cb_r        <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      preb_r      <= 1'b1;
      copy_r      <= '0;
      mode_r      <= MODE_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RATE:   rate_r   <= cfg_data[RATE_W-1:0];
          REG_MAX:    max_r    <= cfg_data;
          REG_PREBUF: prebuf_r <= cfg_data;
          default:    ;
        endcase
      end
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      cb_r    <= cb_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      preb_r  <= preb_nxt;
      copy_r  <= copy_nxt;
      if (cmd.latch) begin
        mode_r <= mode_t'(in_tuser);
      end
      if (cmd.load_status || cmd.load_frame) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      frame_r <= in_tdata;
    end
    if (cmd.decode) begin
      rej_r <= (mode_r == MODE_PUSH) && (cb_r >= eff_max);
    end
    if (cmd.pop_decide) begin
      pop_slot_r <= head_r;
      sil_r      <= !use_blk;
      k_r        <= '0;
    end else if (cmd.frame_next) begin
      k_r <= k_r + 1'b1;
    end
    if (cmd.load_status) begin
      out_status_r <= 1'b1;
      out_sample_r <= '0;
      out_sil_r    <= 1'b0;
      out_last_r   <= 1'b1;
      out_rej_r    <= rej_r;
      out_pct_r    <= fill_pct;
    end else if (cmd.load_frame) begin
      out_status_r <= 1'b0;
      out_sample_r <= sil_r ? '0 : rdata;
      out_sil_r    <= sil_r;
      out_last_r   <= k_r == POS_W'(BLOCK_FRAMES - 1);
      out_rej_r    <= 1'b0;
      out_pct_r    <= fill_pct;
    end
  end

  rabf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.copy_step && keep),
    .waddr (waddr),
    .wdata (frame_r),
    .re    (cmd.frame_rd),
    .raddr (raddr),
    .rdata (rdata)
  );

  rabf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (DIVD_W'(cb_r) * DIVD_W'(FULL_PCT)),
    .divisor  (eff_max),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign fill_pct = (quotient > DIVD_W'(FULL_PCT)) ? PCT_W'(FULL_PCT) : PCT_W'(quotient);
  assign out_fire = out_valid_r && out_tready;

  assign stat.mode       = mode_r;
  assign stat.full       = cb_r >= eff_max;
  assign stat.copy_last  = copy_r == (mult - 1'b1);
  assign stat.div_busy   = div_busy;
  assign stat.out_fire   = out_fire;
  assign stat.frame_last = k_r == POS_W'(BLOCK_FRAMES - 1);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_pct_r, out_sample_r});
  assign out_tuser  = {out_rej_r, out_sil_r, out_status_r};
  assign out_tlast  = out_last_r;

  a_cb_range: assert property (@(posedge clk) disable iff (!rst_n)
    cb_r <= CNT_W'(MAX_BLOCK_COUNT))
    else $error("block count above capacity");

  a_ring_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == tail_r) == (cb_r == '0))
    else $error("head and tail disagree with block count");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop_decide && use_blk) |-> (cb_r != '0))
    else $error("block popped from empty fifo");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_status || cmd.load_frame) |-> !out_valid_r)
    else $error("output register loaded while holding a beat");

endmodule

FILE: rtl/rabf_ctrl.sv
module rabf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  rabf_pkg::stat_t  stat,
  output rabf_pkg::cmd_t   cmd
);
  import rabf_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        unique case (stat.mode)
          MODE_PUSH:  state_nxt = stat.full ? S_DIV_GO : S_PUSH;
          MODE_POP: begin
            cmd.pop_decide = 1'b1;
            state_nxt      = S_DIV_GO;
          end
          MODE_FLUSH: begin
            cmd.flush = 1'b1;
            state_nxt = S_DIV_GO;
          end
          MODE_NONE:  state_nxt = S_IDLE;
        endcase
      end
      S_PUSH: begin
        cmd.copy_step = 1'b1;
        if (stat.copy_last) begin
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!stat.div_busy) begin
          if (stat.mode == MODE_POP) begin
            state_nxt = S_FRM_RD;
          end else begin
            cmd.load_status = 1'b1;
            state_nxt       = S_ST_WAIT;
          end
        end
      end
      S_ST_WAIT: begin
        if (stat.out_fire) begin
          state_nxt = S_IDLE;
        end
      end
      S_FRM_RD: begin
        cmd.frame_rd = 1'b1;
        state_nxt    = S_FRM_LD;
      end
      S_FRM_LD: begin
        cmd.load_frame = 1'b1;
        state_nxt      = S_FRM_WAIT;
      end
      S_FRM_WAIT: begin
        if (stat.out_fire) begin
          if (stat.frame_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.frame_next = 1'b1;
            state_nxt      = S_FRM_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/resampling_audio_block_fifo.sv
// Audio block FIFO with zero-order-hold rate conversion toward 44.1 kHz. Each input beat
// carries a mode in in_tuser: a push repeats the frame by the rate table's multiplier and
// keeps every div-th copy, writing at most one kept frame per cycle into a 33-slot
// block store (one single-port-write RAM); a pop returns one whole block of 64 frames,
// or silence while prebuffering or on underrun; a flush empties the FIFO. Push and flush
// give one status beat, a pop gives 64 beats with tlast on the final one; every beat
// carries the fill percentage, computed after the item by a shift-subtract divider.
// One item is worked at a time (the push multiplier is 1 to 11); a pop sends each frame
// through a RAM read, a load of the output register and its beat. The block store is
// not cleared after reset; silent pops read it too, but send zeros, so no unwritten
// entry reaches the output.
module resampling_audio_block_fifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rabf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rabf_pkg::REG_W-1:0]        cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rabf_pkg::SAMPLE_W-1:0]     in_tdata,   // frame_sample
  input  logic [rabf_pkg::MODE_W-1:0]       in_tuser,   // mode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rabf_pkg::OUT_DATA_W-1:0]   out_tdata,  // out_sample, fill_percent, zero pad
  output logic [rabf_pkg::OUT_USER_W-1:0]   out_tuser,  // is_status, silence, rejected
  output logic                              out_tlast
);
  import rabf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rabf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rabf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
